### rtl/toeplitz_quadratic_form_diag_defines.svh
// Assertion macros for the quadratic form diagonal RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef TOEPLITZ_QUADRATIC_FORM_DIAG_DEFINES_SVH
`define TOEPLITZ_QUADRATIC_FORM_DIAG_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TQF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TQF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tqf_pkg.sv
// Types, widths and pair tables for the quadratic form diagonal block.
// Depends on nothing; imported by the interfaces and every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tqf_pkg;

    localparam int TAPS   = 4;
    localparam int NPAIR  = TAPS * (TAPS - 1) / 2;
    localparam int NLANE  = TAPS + NPAIR;

    localparam int W_W    = 18;
    localparam int POS_W  = 10;
    localparam int T_W    = 32;
    localparam int TW_W   = T_W + W_W;
    localparam int PROD_W = TW_W + W_W;
    localparam int ACC_W  = 72;
    localparam int OUT_W  = 48;
    localparam int RND_SH = 32;
    localparam int GRP    = 4;
    localparam int NGRP   = (NLANE + GRP - 1) / GRP;

    typedef logic signed [W_W-1:0]    t_weight;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [T_W-1:0]    t_tval;
    typedef logic signed [TW_W-1:0]   t_tw;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [OUT_W-1:0]  t_out;

    typedef struct packed {
        logic  en;
        t_pos  addr;
        t_tval data;
    } t_tbl_wr;

    localparam t_acc RND_HALF    = {{(ACC_W-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};
    localparam t_acc ACC_OUT_MAX = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam t_acc ACC_OUT_MIN = {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    // First tap of off-diagonal pair idx, pairs ordered (0,1),(0,2),...,(1,2),...
    function automatic int pair_a(input int idx);
        int n;
        int res;
        n   = 0;
        res = 0;
        for (int j = 0; j < TAPS; j++) begin
            for (int k = j + 1; k < TAPS; k++) begin
                if (n == idx) begin
                    res = j;
                end
                n++;
            end
        end
        return res;
    endfunction

    // Second tap of off-diagonal pair idx.
    function automatic int pair_b(input int idx);
        int n;
        int res;
        n   = 0;
        res = 0;
        for (int j = 0; j < TAPS; j++) begin
            for (int k = j + 1; k < TAPS; k++) begin
                if (n == idx) begin
                    res = k;
                end
                n++;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/tqf_ifs.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on tqf_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface tqf_req_if
    import tqf_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    req_type;
    t_pos    table_addr;
    t_tval   table_value;
    t_weight weight_0;
    t_weight weight_1;
    t_weight weight_2;
    t_weight weight_3;
    t_pos    position_0;
    t_pos    position_1;
    t_pos    position_2;
    t_pos    position_3;

    modport source (
        output valid, req_type, table_addr, table_value,
        output weight_0, weight_1, weight_2, weight_3,
        output position_0, position_1, position_2, position_3,
        input  ready
    );
    modport sink (
        input  valid, req_type, table_addr, table_value,
        input  weight_0, weight_1, weight_2, weight_3,
        input  position_0, position_1, position_2, position_3,
        output ready
    );
endinterface

interface tqf_rsp_if
    import tqf_pkg::*;
();
    logic valid;
    logic ready;
    t_out diag_value;
    logic saturated;

    modport source (output valid, diag_value, saturated, input ready);
    modport sink (input valid, diag_value, saturated, output ready);
endinterface

`default_nettype wire

### rtl/toeplitz_quadratic_form_diag.sv
// Top level of the Toeplitz quadratic form diagonal block.
// Depends on tqf_pkg, tqf_ifs, tqf_table, tqf_lane, tqf_merge and the defines header.
//
// Usage:
//   i_req carries table writes (req_type 0) and row requests (req_type 1).
//   A table write stores table_value at lag table_addr in every table copy
//   and produces no response; addresses past TABLE_DEPTH are dropped.
//   A row request produces one o_rsp transfer: the sum over all tap pairs
//   of table[|pos_j - pos_k|] * w_j * w_k, rounded to Q.24 and saturated.
//   Table read, both lane multiplies, group sums and total are registered in
//   turn before the response. One item per cycle unless the receiver stalls,
//   writes and rows mixed freely; a row may read what the item before wrote.
//   Rate comes from one table copy per off-diagonal pair (six copies of
//   TABLE_DEPTH x 32 bits, one read port each) and one lane per tap pair;
//   lag zero is kept in a register for the four diagonal lanes.
//   Reset clears the pipeline valid bits and the response valid; table
//   contents are not cleared, and a row must only read written entries.
//   When the receiver stalls, the whole pipeline holds and i_req.ready
//   falls until the waiting response is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "toeplitz_quadratic_form_diag_defines.svh"

module toeplitz_quadratic_form_diag
    import tqf_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tqf_req_if.sink   i_req,
    tqf_rsp_if.source o_rsp
);

    localparam int NV = 5;

    logic          w_en;
    logic          w_acc;
    logic          w_row;
    t_tbl_wr       w_wr;
    t_weight       w_w_in [TAPS];
    t_pos          w_pos  [TAPS];
    t_tval         w_t_pair [NPAIR];
    t_prod         w_term [NLANE];

    logic [NV-1:0] r_vld;
    logic          r_out_valid;
    t_tval         r_lag0;
    t_tval         r_t0_s1;
    t_weight       r_w_s1 [TAPS];

    // Advance everything whenever the response register is free or drains.
    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en;
    assign w_acc       = i_req.valid && w_en;
    assign w_row       = w_acc && i_req.req_type;

    assign w_wr.en   = w_acc && !i_req.req_type;
    assign w_wr.addr = i_req.table_addr;
    assign w_wr.data = i_req.table_value;

    assign w_w_in[0] = i_req.weight_0;
    assign w_w_in[1] = i_req.weight_1;
    assign w_w_in[2] = i_req.weight_2;
    assign w_w_in[3] = i_req.weight_3;
    assign w_pos[0]  = i_req.position_0;
    assign w_pos[1]  = i_req.position_1;
    assign w_pos[2]  = i_req.position_2;
    assign w_pos[3]  = i_req.position_3;

    // Valid chain: stage 1 (table read) through stage 5 (total), then response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NV-2:0], w_row};
            r_out_valid <= r_vld[NV-1];
        end
    end

    // Lag zero in a register serves all diagonal lanes at once.
    always_ff @(posedge i_clk) begin
        if (w_wr.en && (w_wr.addr == '0)) begin
            r_lag0 <= w_wr.data;
        end
        if (w_en) begin
            r_t0_s1 <= r_lag0;
            r_w_s1  <= w_w_in;
        end
    end

    // One table copy and one lane per off-diagonal pair.
    for (genvar p = 0; p < NPAIR; p++) begin : g_pair
        localparam int PA = pair_a(p);
        localparam int PB = pair_b(p);

        tqf_table #(
            .DEPTH (TABLE_DEPTH)
        ) u_table (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_wr    (w_wr),
            .i_pos_a (w_pos[PA]),
            .i_pos_b (w_pos[PB]),
            .o_t     (w_t_pair[p])
        );

        tqf_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_t    (w_t_pair[p]),
            .i_wa   (r_w_s1[PA]),
            .i_wb   (r_w_s1[PB]),
            .o_term (w_term[TAPS + p])
        );
    end

    // Diagonal lanes: table[0] * w_j * w_j.
    for (genvar d = 0; d < TAPS; d++) begin : g_diag
        tqf_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_t    (r_t0_s1),
            .i_wa   (r_w_s1[d]),
            .i_wb   (r_w_s1[d]),
            .o_term (w_term[d])
        );
    end

    tqf_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_term (w_term),
        .o_diag (o_rsp.diag_value),
        .o_sat  (o_rsp.saturated)
    );

    assign o_rsp.valid = r_out_valid;

    `TQF_ASSERT_NEXT(a_row_enters, i_clk, i_rst_n, w_row, r_vld[0], "row transfer lost at stage 1")
    `TQF_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, w_wr.en, !r_vld[0], "table write made a row")
    `TQF_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_vld), "pipeline moved on stall")
    `TQF_ASSERT_NOW(a_no_clip, i_clk, i_rst_n, o_rsp.valid, !o_rsp.saturated, "sum out of range")

endmodule

`default_nettype wire

### rtl/tqf_table.sv
// One copy of the lag table: absolute lag of a position pair, registered read.
// Depends on tqf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tqf_table
    import tqf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_tbl_wr i_wr,
    input  t_pos    i_pos_a,
    input  t_pos    i_pos_b,
    output t_tval   o_t
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_tval r_mem [DEPTH];
    t_tval r_rd;
    logic  r_oor;
    t_pos  w_lag;
    logic  w_wr_ok;

    assign w_lag   = (i_pos_a > i_pos_b) ? (i_pos_a - i_pos_b) : (i_pos_b - i_pos_a);
    assign w_wr_ok = i_wr.en && (32'(i_wr.addr) < DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        if (i_en) begin
            r_rd  <= r_mem[AW'(w_lag)];
            r_oor <= !(32'(w_lag) < DEPTH);
        end
    end

    // A lag past the table reads as zero.
    assign o_t = r_oor ? '0 : r_rd;

endmodule

`default_nettype wire

### rtl/tqf_lane.sv
// One product lane: table value times two weights, two registered multiplies.
// Depends on tqf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tqf_lane
    import tqf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_tval   i_t,
    input  t_weight i_wa,
    input  t_weight i_wb,
    output t_prod   o_term
);

    t_tw     w_tw;
    t_prod   w_prod;
    t_tw     r_tw;
    t_weight r_wb;
    t_prod   r_term;

    assign w_tw   = TW_W'(i_t) * TW_W'(i_wa);
    assign w_prod = PROD_W'(r_tw) * PROD_W'(r_wb);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tw   <= w_tw;
            r_wb   <= i_wb;
            r_term <= w_prod;
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

### rtl/tqf_merge.sv
// Merge stage: doubles off-diagonal terms, sums all lanes in a registered
// tree, rounds to 24 fraction bits and saturates. Depends on tqf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tqf_merge
    import tqf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_prod i_term [NLANE],
    output t_out  o_diag,
    output logic  o_sat
);

    t_acc w_scaled [NLANE];
    t_acc w_grp    [NGRP];
    t_acc r_grp    [NGRP];
    t_acc r_total;
    t_acc w_total;
    t_acc w_rnd;
    t_acc w_sh;
    t_acc w_clip;
    logic w_sat;
    t_out r_diag;
    logic r_sat;

    // Off-diagonal lanes stand for both (j,k) and (k,j).
    for (genvar l = 0; l < NLANE; l++) begin : g_scale
        if (l < TAPS) begin : g_diag
            assign w_scaled[l] = ACC_W'(i_term[l]);
        end else begin : g_pair
            assign w_scaled[l] = ACC_W'(i_term[l]) <<< 1;
        end
    end

    always_comb begin
        int idx;
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int i = 0; i < GRP; i++) begin
                idx = g * GRP + i;
                if (idx < NLANE) begin
                    w_grp[g] = w_grp[g] + w_scaled[idx];
                end
            end
        end
    end

    always_comb begin
        w_total = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_total = w_total + r_grp[g];
        end
    end

    // Round half up, then clip to the output range.
    assign w_rnd = r_total + RND_HALF;
    assign w_sh  = w_rnd >>> RND_SH;

    always_comb begin
        w_clip = w_sh;
        w_sat  = 1'b0;
        if (w_sh > ACC_OUT_MAX) begin
            w_clip = ACC_OUT_MAX;
            w_sat  = 1'b1;
        end else if (w_sh < ACC_OUT_MIN) begin
            w_clip = ACC_OUT_MIN;
            w_sat  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp   <= w_grp;
            r_total <= w_total;
            r_diag  <= w_clip[OUT_W-1:0];
            r_sat   <= w_sat;
        end
    end

    assign o_diag = r_diag;
    assign o_sat  = r_sat;

endmodule

`default_nettype wire

### verif/toeplitz_quadratic_form_diag_tb.sv
// Self-checking bench for the Toeplitz quadratic form diagonal block.
// Depends on tqf_pkg, tqf_ifs and toeplitz_quadratic_form_diag from the rtl folder.
`timescale 1ns / 1ps

module toeplitz_quadratic_form_diag_tb
    import tqf_pkg::*;
();

    localparam int DEPTH       = 1024;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Request kinds carried by req_type.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_ROW   = 1'b1;

    localparam t_weight W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam t_weight W_MIN = {1'b1, {(W_W-1){1'b0}}};
    localparam t_tval   T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam t_tval   T_MIN = {1'b1, {(T_W-1){1'b0}}};
    localparam t_tval   T_ONE = 32'sh0100_0000;   // 1.0 in Q.24

    // Output range of the Q.24 result, held at accumulator width.
    localparam logic signed [127:0] DIAG_MAX = (128'sd1 <<< (OUT_W-1)) - 128'sd1;
    localparam logic signed [127:0] DIAG_MIN = -(128'sd1 <<< (OUT_W-1));

    typedef struct {
        logic    req_type;
        t_pos    addr;
        t_tval   value;
        t_weight w [TAPS];
        t_pos    p [TAPS];
    } t_tqf_item;

    typedef struct {
        t_out diag;
        logic sat;
    } t_diag_result;

    logic clk;
    logic rst_n;

    tqf_req_if req_if ();
    tqf_rsp_if rsp_if ();

    toeplitz_quadratic_form_diag dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Mirror of the lag table as the block should hold it, plus which lags
    // have been written; rows only ever read lags marked here.
    t_tval        lag_mirror  [DEPTH];
    bit           lag_written [DEPTH];
    int           next_unwritten;
    t_diag_result expected_diags [$];

    int  diag_mismatches;
    int  cycle_count;
    bit  bursts_on;
    int  stall_left;

    // Free-running clock, 10 ns period.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run if the pipeline or the stimulus hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("toeplitz_quadratic_form_diag verification failed");
            $finish;
        end
    end

    // Response sink: hold ready low in random bursts while bursts are enabled,
    // otherwise keep it high. Change only on falling edges.
    initial begin
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Exact quadratic form over all ordered tap pairs, then round half up to
    // Q.24 and clip to 48 bits. At these widths the clip never fires, but the
    // saturated flag is still predicted from the same comparison.
    function automatic t_diag_result predict_diag(input t_tqf_item it);
        logic signed [127:0] acc;
        logic signed [127:0] tv;
        logic signed [127:0] wj;
        logic signed [127:0] wk;
        logic signed [127:0] rounded;
        int                  lag;
        t_diag_result        res;
        acc = '0;
        for (int j = 0; j < TAPS; j++) begin
            for (int k = 0; k < TAPS; k++) begin
                lag = int'(it.p[j]) - int'(it.p[k]);
                if (lag < 0) begin
                    lag = -lag;
                end
                tv  = lag_mirror[lag];
                wj  = it.w[j];
                wk  = it.w[k];
                acc = acc + tv * wj * wk;
            end
        end
        rounded = (acc + (128'sd1 <<< (RND_SH-1))) >>> RND_SH;
        res.sat = 1'b0;
        if (rounded > DIAG_MAX) begin
            rounded = DIAG_MAX;
            res.sat = 1'b1;
        end else if (rounded < DIAG_MIN) begin
            rounded = DIAG_MIN;
            res.sat = 1'b1;
        end
        res.diag = rounded[OUT_W-1:0];
        return res;
    endfunction

    function automatic t_weight rand_weight();
        case ($urandom_range(0, 11))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3:       return t_weight'(1);
            default: return t_weight'($urandom());
        endcase
    endfunction

    function automatic t_tval rand_tval();
        case ($urandom_range(0, 11))
            0:       return T_MAX;
            1:       return T_MIN;
            2:       return '0;
            3:       return -t_tval'(1);
            default: return t_tval'($urandom());
        endcase
    endfunction

    // Fill the fields a request kind ignores with random bits, so every
    // input bit toggles whatever the kind.
    function automatic t_tqf_item make_write(input int addr, input t_tval value);
        t_tqf_item it;
        it.req_type = REQ_WRITE;
        it.addr     = t_pos'(addr);
        it.value    = value;
        for (int j = 0; j < TAPS; j++) begin
            it.w[j] = t_weight'($urandom());
            it.p[j] = t_pos'($urandom());
        end
        return it;
    endfunction

    function automatic t_tqf_item make_row(input t_weight w0, w1, w2, w3,
                                           input int p0, p1, p2, p3);
        t_tqf_item it;
        it.req_type = REQ_ROW;
        it.addr     = t_pos'($urandom());
        it.value    = t_tval'($urandom());
        it.w[0] = w0;
        it.w[1] = w1;
        it.w[2] = w2;
        it.w[3] = w3;
        it.p[0] = t_pos'(p0);
        it.p[1] = t_pos'(p1);
        it.p[2] = t_pos'(p2);
        it.p[3] = t_pos'(p3);
        return it;
    endfunction

    // Random item that never reads an unwritten lag. Rows come in two shapes:
    // a window no wider than the written prefix of the table, or two points
    // a written lag apart, which reaches far lags long before the table fills.
    function automatic t_tqf_item random_item();
        t_tqf_item it;
        int        span;
        int        base;
        int        lag;
        if ($urandom_range(0, 99) < 35) begin
            if (next_unwritten < DEPTH && $urandom_range(0, 1) == 0) begin
                it = make_write(next_unwritten, rand_tval());
            end else begin
                it = make_write($urandom_range(0, POS_MAX), rand_tval());
            end
        end else begin
            it = make_row(rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                          0, 0, 0, 0);
            if ($urandom_range(0, 1) == 0) begin
                span = next_unwritten - 1;
                base = $urandom_range(0, POS_MAX - span);
                for (int j = 0; j < TAPS; j++) begin
                    it.p[j] = t_pos'(base + $urandom_range(0, span));
                end
            end else begin
                do begin
                    lag = $urandom_range(0, POS_MAX);
                end while (!lag_written[lag]);
                base = $urandom_range(0, POS_MAX - lag);
                for (int j = 0; j < TAPS; j++) begin
                    it.p[j] = t_pos'($urandom_range(0, 1) ? base + lag : base);
                end
            end
        end
        return it;
    endfunction

    // Drive one item on the falling edge, hold it until the transfer, then
    // update the table mirror or queue the expected diagonal value.
    task automatic send_item(input t_tqf_item it);
        int gap;
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.req_type    <= it.req_type;
        req_if.table_addr  <= it.addr;
        req_if.table_value <= it.value;
        req_if.weight_0    <= it.w[0];
        req_if.weight_1    <= it.w[1];
        req_if.weight_2    <= it.w[2];
        req_if.weight_3    <= it.w[3];
        req_if.position_0  <= it.p[0];
        req_if.position_1  <= it.p[1];
        req_if.position_2  <= it.p[2];
        req_if.position_3  <= it.p[3];
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        if (it.req_type == REQ_ROW) begin
            expected_diags.push_back(predict_diag(it));
        end else begin
            // A 10-bit address always lands inside a 1024-deep table, so the
            // out-of-range write drop cannot be reached from this port.
            lag_mirror[it.addr]  = it.value;
            lag_written[it.addr] = 1'b1;
            while (next_unwritten < DEPTH && lag_written[next_unwritten]) begin
                next_unwritten++;
            end
        end
    endtask

    // Drop valid and wait until every queued row has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_diags.size() != 0) @(posedge clk);
    endtask

    task automatic report_miss(input string what, input t_diag_result want,
                               input t_out got_diag, input logic got_sat);
        diag_mismatches++;
        if (diag_mismatches <= MAX_REPORTS) begin
            $display("%0t: %s: expected diag %0d sat %0b, got diag %0d sat %0b",
                     $realtime, what, want.diag, want.sat, got_diag, got_sat);
        end
    endtask

    // Response checker: compare every transfer with the oldest expectation.
    always @(posedge clk) begin
        t_diag_result want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_diags.size() == 0) begin
                want.diag = 'x;
                want.sat  = 1'bx;
                report_miss("unexpected response", want, rsp_if.diag_value,
                            rsp_if.saturated);
            end else begin
                want = expected_diags.pop_front();
                if (rsp_if.diag_value !== want.diag || rsp_if.saturated !== want.sat) begin
                    report_miss("response mismatch", want, rsp_if.diag_value,
                                rsp_if.saturated);
                end
            end
        end
    end

    // Field extremes: largest and smallest table values and weights, the
    // longest lag, and a row shifted by one position, which must match the
    // unshifted row because only position differences matter.
    task automatic test_directed_extremes();
        send_item(make_write(0, T_MAX));
        send_item(make_write(1, T_MIN));
        send_item(make_write(2, -t_tval'(1)));
        send_item(make_write(3, T_ONE));
        send_item(make_write(POS_MAX, T_MIN));
        send_item(make_write(512, rand_tval()));
        send_item(make_row(W_MAX, W_MAX, W_MAX, W_MAX, 0, 0, 0, 0));
        send_item(make_row(W_MIN, W_MIN, W_MIN, W_MIN, 0, 1, 2, 3));
        send_item(make_row(W_MIN, W_MIN, W_MIN, W_MIN, 1, 2, 3, 4));
        send_item(make_row(W_MAX, W_MIN, W_MAX, W_MIN, 1020, 1021, 1022, POS_MAX));
        send_item(make_row(W_MIN, W_MIN, W_MIN, W_MIN, 0, POS_MAX, POS_MAX, 0));
        send_item(make_row(rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                           511, POS_MAX, 511, POS_MAX));
        send_item(make_row('0, '0, '0, '0, 700, 700, 700, 700));
    endtask

    // Rounding at exactly one half LSB: a positive half rounds up, a
    // negative half rounds toward plus infinity, i.e. to zero.
    task automatic test_rounding();
        send_item(make_write(0, 32'sh0800_0000));
        send_item(make_row(t_weight'(4), '0, '0, '0, 9, 9, 9, 9));
        send_item(make_row(-t_weight'(4), '0, '0, '0, 9, 9, 9, 9));
        send_item(make_write(0, -32'sh0800_0000));
        send_item(make_row(t_weight'(4), '0, '0, '0, 9, 9, 9, 9));
        send_item(make_row(t_weight'(3), '0, '0, '0, 9, 9, 9, 9));
        send_item(make_write(0, rand_tval()));
    endtask

    // Bulk random traffic with idle bursts on both sides; halfway through,
    // hold the sender until the pipeline is empty.
    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                hold_until_drained();
            end
            send_item(random_item());
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate(input int count);
        bursts_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
        end
    endtask

    initial begin
        diag_mismatches = 0;
        cycle_count     = 0;
        next_unwritten  = 0;
        bursts_on       = 1'b1;
        for (int a = 0; a < DEPTH; a++) begin
            lag_mirror[a]  = '0;
            lag_written[a] = 1'b0;
        end

        // Hold every block input at a known value from time zero.
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_WRITE;
        req_if.table_addr  = '0;
        req_if.table_value = '0;
        req_if.weight_0    = '0;
        req_if.weight_1    = '0;
        req_if.weight_2    = '0;
        req_if.weight_3    = '0;
        req_if.position_0  = '0;
        req_if.position_1  = '0;
        req_if.position_2  = '0;
        req_if.position_3  = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_rounding();
        test_random_mix(1680);
        test_full_rate(150);

        // Drain, then give the pipeline room to show any extra response
        // before judging.
        hold_until_drained();
        repeat (12) @(posedge clk);

        if (diag_mismatches == 0 && expected_diags.size() == 0) begin
            $display("toeplitz_quadratic_form_diag verification clean");
        end else begin
            $display("toeplitz_quadratic_form_diag verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tqf_pkg.sv
rtl/tqf_ifs.sv
rtl/tqf_table.sv
rtl/tqf_lane.sv
rtl/tqf_merge.sv
rtl/toeplitz_quadratic_form_diag.sv
verif/toeplitz_quadratic_form_diag_tb.sv
